// File: design/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants for the chained hash map
// Request and response transaction structs, operation codes, default sizes.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int unsigned DEF_BUCKETS    = 64;
	localparam int unsigned DEF_ENTRIES    = 256;
	localparam int unsigned DEF_KEY_BITS   = 32;
	localparam int unsigned DEF_VALUE_BITS = 32;

	localparam logic [1:0] OP_PUT      = 2'd0;
	localparam logic [1:0] OP_GET      = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;
	localparam logic [1:0] OP_CONTAINS = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        found;
		logic [8:0]  entry_count;
		logic        full_error;
	} rsp_t;

endpackage

// File: design/chained_hash_map.sv
// ----------------------------------------------------------------------------
// chained_hash_map: key-value map with separate chaining
// Buckets hold chain heads; slots come from a free stack kept in memory.
// ----------------------------------------------------------------------------
// channel | dir | payload       | handshake
// req     | in  | chm_pkg::req_t | req_valid / req_stall
// rsp     | out | chm_pkg::rsp_t | rsp_valid / rsp_stall
//
// Operation: one request at a time; after the bucket head is read, each chain
//   entry is examined until a hit, and a PUT miss then links a free slot.
//   Every chain step is one synchronous read of the slot memory.
// Reset: a clearing pass empties the buckets and refills the free
//   stack; req_stall is high meanwhile.
// Stalls: a response waits in its register and holds off the next request;
//   that request is taken the cycle after the response leaves.
module chained_hash_map #(
	parameter int unsigned BUCKETS    = chm_pkg::DEF_BUCKETS,
	parameter int unsigned ENTRIES    = chm_pkg::DEF_ENTRIES,
	parameter int unsigned KEY_BITS   = chm_pkg::DEF_KEY_BITS,
	parameter int unsigned VALUE_BITS = chm_pkg::DEF_VALUE_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  chm_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output chm_pkg::rsp_t  rsp
);
	import chm_pkg::*;

	localparam int unsigned SW = $clog2(ENTRIES + 1);   // slot index incl. nil
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned CLR = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
	localparam int unsigned CW = $clog2(CLR + 1);
	localparam logic [SW-1:0] NIL = SW'(ENTRIES);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_HEAD   = 4'd2;
	localparam logic [3:0] ST_HEADW  = 4'd3;
	localparam logic [3:0] ST_SLOT   = 4'd4;
	localparam logic [3:0] ST_CHECK  = 4'd5;
	localparam logic [3:0] ST_FREE   = 4'd6;
	localparam logic [3:0] ST_FREEW  = 4'd7;
	localparam logic [3:0] ST_RSP    = 4'd8;

	// memories
	logic [SW-1:0]         head_mem [BUCKETS];
	logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
	logic [SW-1:0]         next_mem [ENTRIES];
	logic [AW-1:0]         free_mem [ENTRIES];

	logic [3:0]            state_q;
	logic [CW-1:0]         clr_q;
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BW-1:0]         bkt_q;
	logic [SW-1:0]         cur_q, prev_q, head_q;
	logic [SW-1:0]         free_cnt_q, stored_q;
	logic [SW-1:0]         steps_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// registered read data
	logic [SW-1:0]         head_rd;
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;
	logic [SW-1:0]         next_rd;
	logic [AW-1:0]         free_rd;

	// read addresses / write strobes (combinational)
	logic [BW-1:0]         head_ra;
	logic [AW-1:0]         slot_ra, free_ra;
	logic                  head_we, slot_we, next_we, free_we;
	logic [BW-1:0]         head_wa;
	logic [SW-1:0]         head_wd;
	logic [AW-1:0]         slot_wa, next_wa, free_wa;
	logic [SW-1:0]         next_wd;
	logic [AW-1:0]         free_wd;
	logic                  val_we;

	logic [KEY_BITS-1:0]   in_key;
	logic                  accept;

	assign in_key    = KEY_BITS'(req.key);
	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		// the input payload may move on once taken; use the latched bucket
		head_ra = (state_q == ST_IDLE) ? BW'(in_key % BUCKETS) : bkt_q;
		slot_ra = cur_q[AW-1:0];
		free_ra = AW'(free_cnt_q - SW'(1));
	end

	always_ff @(posedge clk) begin
		head_rd <= head_mem[head_ra];
		key_rd  <= key_mem[slot_ra];
		val_rd  <= val_mem[slot_ra];
		next_rd <= next_mem[slot_ra];
		free_rd <= free_mem[free_ra];
		if (head_we) head_mem[head_wa] <= head_wd;
		if (slot_we) key_mem[slot_wa] <= key_q;
		if (val_we)  val_mem[slot_wa] <= val_q;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (free_we) free_mem[free_wa] <= free_wd;
	end

	logic hit;
	assign hit = (key_rd == key_q);

	always_comb begin
		head_we = 1'b0; head_wa = bkt_q;      head_wd = NIL;
		slot_we = 1'b0; val_we  = 1'b0;       slot_wa = free_rd;
		next_we = 1'b0; next_wa = prev_q[AW-1:0]; next_wd = next_rd;
		free_we = 1'b0; free_wa = free_cnt_q[AW-1:0]; free_wd = cur_q[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				if (clr_q < CW'(BUCKETS)) begin
					head_we = 1'b1;
					head_wa = BW'(clr_q);
				end
				if (clr_q < CW'(ENTRIES)) begin
					free_we = 1'b1;
					free_wa = AW'(clr_q);
					free_wd = AW'(clr_q);
				end
			end
			ST_CHECK: begin
				if (hit && op_q == OP_PUT) begin
					val_we  = 1'b1;
					slot_wa = cur_q[AW-1:0];
				end else if (hit && op_q == OP_REMOVE) begin
					if (prev_q != NIL) next_we = 1'b1;
					else begin
						head_we = 1'b1;
						head_wd = next_rd;
					end
					free_we = (free_cnt_q < NIL);
				end
			end
			ST_FREEW: begin
				// link a fresh slot at the chain head
				slot_we = 1'b1;
				val_we  = 1'b1;
				next_we = 1'b1;
				next_wa = free_rd;
				next_wd = head_q;
				head_we = 1'b1;
				head_wd = SW'(free_rd);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			free_cnt_q  <= NIL;
			stored_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						prev_q  <= NIL;
						steps_q <= '0;
						rsp_q.read_value <= '0;
						rsp_q.full_error <= 1'b0;
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: state_q <= ST_HEADW;
				ST_HEADW: begin
					head_q <= head_rd;
					cur_q  <= head_rd;
					state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					if (cur_q == NIL || steps_q == NIL) begin
						rsp_q.found <= 1'b0;
						if (op_q == OP_PUT) begin
							if (free_cnt_q == '0) begin
								rsp_q.full_error <= 1'b1;
								state_q <= ST_RSP;
							end else begin
								state_q <= ST_FREE;
							end
						end else begin
							state_q <= ST_RSP;
						end
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (hit) begin
						rsp_q.found <= 1'b1;
						if (op_q == OP_GET) rsp_q.read_value <= 32'(val_rd);
						if (op_q == OP_REMOVE) begin
							if (free_cnt_q < NIL) free_cnt_q <= free_cnt_q + SW'(1);
							if (stored_q != '0) stored_q <= stored_q - SW'(1);
						end
						state_q <= ST_RSP;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= next_rd;
						steps_q <= steps_q + SW'(1);
						state_q <= ST_SLOT;
					end
				end
				ST_FREE: state_q <= ST_FREEW;
				ST_FREEW: begin
					free_cnt_q <= free_cnt_q - SW'(1);
					stored_q   <= stored_q + SW'(1);
					state_q    <= ST_RSP;
				end
				ST_RSP: begin
					rsp_q.entry_count <= 9'(stored_q);
					rsp_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			key_q  <= in_key;
			val_q  <= VALUE_BITS'(req.value);
			bkt_q  <= head_ra;
		end
	end

`ifndef SYNTHESIS
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (32'(free_cnt_q) + 32'(stored_q) == ENTRIES))
		else $error("free and stored counts disagree");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("request taken while busy");
	a_rsp_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RSP) |-> !rsp_valid_q)
		else $error("response overwritten");
	a_full_only_put: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.full_error) |-> !rsp_q.found)
		else $error("full error on a hit");
`endif

endmodule
